### rtl/ndt_pkg.sv
// Package for the name directory table: sizes, action and status codes,
// and the packed word types of the input and result channels.
// Depends on nothing.
package ndt_pkg;

  localparam int ENTRIES    = 64;
  localparam int SLOT_W     = 6;
  localparam int NAME_BYTES = 8;
  localparam int NAME_W     = 64;
  localparam int SECTOR_W   = 10;
  localparam int RAM_W      = NAME_W + SECTOR_W;

  localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  localparam logic [2:0] ACT_FIND     = 3'd0;
  localparam logic [2:0] ACT_FIND_DIR = 3'd1;
  localparam logic [2:0] ACT_ADD_FILE = 3'd2;
  localparam logic [2:0] ACT_ADD_DIR  = 3'd3;
  localparam logic [2:0] ACT_REMOVE   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_PRESENT   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]          action;
    logic [NAME_W-1:0]   entry_name;
    logic [SECTOR_W-1:0] sector_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SECTOR_W-1:0] sector_out;
    logic [SLOT_W-1:0]   slot;
  } out_word_t;

endpackage

### rtl/ndt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module ndt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/name_directory_table_top.sv
// Top level of the name directory table: scan sequencer, valid and directory
// marks, and the result register. Depends on ndt_pkg and ndt_ram.
//
//   channel  ports                     handshake
//   input    in_word                   taken when start is high and busy is low
//   result   out_word                  shown for one cycle with out_strobe
//
// A find, find-directory, add or remove scans the entries one per cycle through
// the key RAM read port and a single name comparator, and a match ends the scan
// early. An unused action code skips the scan and goes to the finish state.
// Reset clears all valid marks at once.
// The result cannot be stalled; busy falls in the cycle the result is shown.
module name_directory_table_top
  import ndt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [2:0]          action_r, action_nxt;
  logic [NAME_W-1:0]   key_r, key_nxt;
  logic [SECTOR_W-1:0] sec_r, sec_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [SLOT_W-1:0]   hit_slot_r, hit_slot_nxt;
  logic [SECTOR_W-1:0] hit_sec_r, hit_sec_nxt;
  logic                free_r, free_nxt;
  logic [SLOT_W-1:0]   free_slot_r, free_slot_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  dir_r, dir_nxt;
  logic                strobe_r, strobe_nxt;
  out_word_t           out_r, out_nxt;

  logic                issue;
  logic                match;
  logic                need_dir;
  logic                is_add;
  logic                ram_we;
  logic [RAM_W-1:0]    ram_rdata;
  logic [NAME_W-1:0]   rd_key;
  logic [SECTOR_W-1:0] rd_sec;

  ndt_ram #(
    .WIDTH(RAM_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_slot_r),
    .wdata({key_r, sec_r}),
    .re   (issue),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  assign rd_key   = ram_rdata[RAM_W-1:SECTOR_W];
  assign rd_sec   = ram_rdata[SECTOR_W-1:0];
  assign need_dir = (action_r == ACT_FIND_DIR);
  assign is_add   = (action_r == ACT_ADD_FILE) || (action_r == ACT_ADD_DIR);
  assign issue    = (state_r == S_SCAN) && !issue_done_r;
  assign match    = cmp_vld_r && valid_r[cmp_idx_r] && (rd_key == key_r)
                    && (!need_dir || dir_r[cmp_idx_r]);
  assign ram_we   = (state_r == S_FINISH) && is_add && !hit_r && free_r;

  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    sec_nxt        = sec_r;
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = idx_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    hit_sec_nxt    = hit_sec_r;
    free_nxt       = free_r;
    free_slot_nxt  = free_slot_r;
    valid_nxt      = valid_r;
    dir_nxt        = dir_r;
    strobe_nxt     = 1'b0;
    out_nxt        = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          action_nxt     = in_word.action;
          key_nxt        = in_word.entry_name & NAME_MASK;
          sec_nxt        = in_word.sector_in;
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          hit_nxt        = 1'b0;
          free_nxt       = 1'b0;
          if (in_word.action == ACT_FIND || in_word.action == ACT_FIND_DIR
              || in_word.action == ACT_ADD_FILE || in_word.action == ACT_ADD_DIR
              || in_word.action == ACT_REMOVE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          cmp_vld_nxt = 1'b1;
          if (!free_r && !valid_r[idx_r]) begin
            free_nxt      = 1'b1;
            free_slot_nxt = idx_r;
          end
          if (idx_r == LAST_SLOT) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (match) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = cmp_idx_r;
          hit_sec_nxt  = rd_sec;
          cmp_vld_nxt  = 1'b0;
          state_nxt    = S_FINISH;
        end else if (cmp_vld_r && cmp_idx_r == LAST_SLOT) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        strobe_nxt = 1'b1;
        out_nxt    = '{status: ST_NOT_FOUND, sector_out: '0, slot: '0};
        if (action_r == ACT_FIND || action_r == ACT_FIND_DIR) begin
          if (hit_r) begin
            out_nxt = '{status: ST_OK, sector_out: hit_sec_r, slot: hit_slot_r};
          end
        end else if (is_add) begin
          if (hit_r) begin
            out_nxt.status = ST_PRESENT;
          end else if (!free_r) begin
            out_nxt.status = ST_FULL;
          end else begin
            out_nxt.status         = ST_OK;
            out_nxt.slot           = free_slot_r;
            valid_nxt[free_slot_r] = 1'b1;
            dir_nxt[free_slot_r]   = (action_r == ACT_ADD_DIR);
          end
        end else if (action_r == ACT_REMOVE) begin
          if (hit_r) begin
            out_nxt.status        = ST_OK;
            out_nxt.slot          = hit_slot_r;
            valid_nxt[hit_slot_r] = 1'b0;
            dir_nxt[hit_slot_r]   = 1'b0;
          end
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      dir_r     <= '0;
      strobe_r  <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      dir_r     <= dir_nxt;
      strobe_r  <= strobe_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    sec_r        <= sec_nxt;
    idx_r        <= idx_nxt;
    issue_done_r <= issue_done_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_sec_r    <= hit_sec_nxt;
    free_r       <= free_nxt;
    free_slot_r  <= free_slot_nxt;
    out_r        <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_word   = out_r;

endmodule

### dv/ndt_result_checker.sv
// Result checker for the name directory table: keeps its own copy of the table,
// predicts one result word per accepted input word and compares what the block shows.
// Depends on ndt_pkg.
module ndt_result_checker
  import ndt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_strobe,
  input  out_word_t out_word,
  output int        errors,
  output int        pending,
  output int        results_seen,
  output int        full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                t_valid  [ENTRIES];
  logic                t_is_dir [ENTRIES];
  logic [NAME_W-1:0]   t_key    [ENTRIES];
  logic [SECTOR_W-1:0] t_sector [ENTRIES];
  out_word_t           expected_q[$];

  function automatic int matching_slot(input logic [NAME_W-1:0] key, input logic need_dir);
    for (int i = 0; i < ENTRIES; i++) begin
      if (t_valid[i] && t_key[i] == key && (!need_dir || t_is_dir[i]))
        return i;
    end
    return -1;
  endfunction

  function automatic out_word_t table_step(input in_word_t w);
    out_word_t         r;
    logic [NAME_W-1:0] key;
    int                hit;
    r = '0;
    r.status = ST_NOT_FOUND;
    key = w.entry_name & NAME_MASK;
    case (w.action)
      ACT_FIND, ACT_FIND_DIR: begin
        hit = matching_slot(key, w.action == ACT_FIND_DIR);
        if (hit >= 0) begin
          r.status     = ST_OK;
          r.sector_out = t_sector[hit];
          r.slot       = SLOT_W'(hit);
        end
      end
      ACT_ADD_FILE, ACT_ADD_DIR: begin
        if (matching_slot(key, 1'b0) >= 0) begin
          r.status = ST_PRESENT;
        end else begin
          hit = -1;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!t_valid[i]) hit = i;
          if (hit < 0) begin
            r.status = ST_FULL;
          end else begin
            t_valid[hit]  = 1'b1;
            t_is_dir[hit] = (w.action == ACT_ADD_DIR);
            t_key[hit]    = key;
            t_sector[hit] = w.sector_in;
            r.status      = ST_OK;
            r.slot        = SLOT_W'(hit);
          end
        end
      end
      ACT_REMOVE: begin
        hit = matching_slot(key, 1'b0);
        if (hit >= 0) begin
          t_valid[hit]  = 1'b0;
          t_is_dir[hit] = 1'b0;
          r.status      = ST_OK;
          r.slot        = SLOT_W'(hit);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    int        fails_now;
    fails_now = 0;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        t_valid[i]  = 1'b0;
        t_is_dir[i] = 1'b0;
        t_key[i]    = '0;
        t_sector[i] = '0;
      end
      expected_q.delete();
      errors       <= 0;
      pending      <= 0;
      results_seen <= 0;
      full_seen    <= 0;
    end else begin
      if ($isunknown({busy, out_strobe})) begin
        $display("%0t: handshake unknown, expected busy and out_strobe known, got %b %b",
                 $time, busy, out_strobe);
        fails_now++;
      end
      if (out_strobe === 1'b1) begin
        results_seen <= results_seen + 1;
        if (out_word.status == ST_FULL) full_seen <= full_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, out_word);
          fails_now++;
        end else begin
          want = expected_q.pop_front();
          if (out_word.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_word.status);
            fails_now++;
          end
          if (out_word.sector_out !== want.sector_out) begin
            $display("%0t: sector_out mismatch, expected %0d, got %0d",
                     $time, want.sector_out, out_word.sector_out);
            fails_now++;
          end
          if (out_word.slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, got %0d",
                     $time, want.slot, out_word.slot);
            fails_now++;
          end
        end
      end
      if (start && busy === 1'b0)
        expected_q.push_back(table_step(in_word));
      pending <= expected_q.size();
      errors  <= errors + fails_now;
    end
  end

endmodule

### dv/name_directory_table_top_test.sv
// Testbench top for the name directory table: clock, reset, directed and random
// command words, sender gaps and the verdict. Depends on ndt_pkg,
// name_directory_table_top and ndt_result_checker.
module name_directory_table_top_test;
  import ndt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_LAST_CODE  = 3'd7;
  localparam int         POOL_SIZE      = 96;
  localparam int         PHASE_WORDS    = 533;
  localparam int         WATCHDOG_LIMIT = 2000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;

  int errors, pending, results_seen, full_seen;
  int idle_pct;
  int words_sent;
  int directed_words;
  int quiet_cycles;
  logic [NAME_W-1:0] name_pool [POOL_SIZE];

  always #1 clk = ~clk;

  name_directory_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  ndt_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_word      (in_word),
    .out_strobe   (out_strobe),
    .out_word     (out_word),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .full_seen    (full_seen)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [NAME_W-1:0] fresh_name();
    logic [NAME_W-1:0] n;
    int                len;
    n   = {$urandom, $urandom};
    len = $urandom_range(NAME_BYTES, 1);
    if (len < NAME_BYTES) n = n & ((64'd1 << (8 * len)) - 64'd1);
    case ($urandom_range(19))
      0: n = '0;
      1: n = '1;
      2: n[15:8] = 8'h00;
      default: ;
    endcase
    return n;
  endfunction

  function automatic in_word_t random_word(input mix_t mix, input int lo, input int n);
    in_word_t w;
    int       p_add, p_find, p_fdir, r;
    case (mix)
      MIX_FILL:  begin p_add = 70; p_find = 15; p_fdir = 7;  end
      MIX_DRAIN: begin p_add = 15; p_find = 18; p_fdir = 7;  end
      default:   begin p_add = 30; p_find = 35; p_fdir = 12; end
    endcase
    w.sector_in = SECTOR_W'($urandom_range(1023));
    r = $urandom_range(99);
    if ($urandom_range(99) < 3)
      w.action = 3'($urandom_range(ACT_LAST_CODE, ACT_REMOVE + 1));
    else if (r < p_add)
      w.action = (r % 3 == 0) ? ACT_ADD_DIR : ACT_ADD_FILE;
    else if (r < p_add + p_find)
      w.action = ACT_FIND;
    else if (r < p_add + p_find + p_fdir)
      w.action = ACT_FIND_DIR;
    else
      w.action = ACT_REMOVE;
    if (w.action != ACT_ADD_FILE && w.action != ACT_ADD_DIR && $urandom_range(99) < 12)
      w.entry_name = {$urandom, $urandom};
    else
      w.entry_name = name_pool[lo + $urandom_range(n - 1)];
    return w;
  endfunction

  initial begin
    mix_t mix;
    int   pool_n, pool_lo, burst, phase_start;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    idle_pct   = 0;
    words_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words on an empty table, then edge-case names and reuse of freed slots.
    idle_pct = 23;
    send_word(in_word_t'{ACT_FIND,     64'h0,                  10'd0});
    send_word(in_word_t'{ACT_REMOVE,   64'h0,                  10'd0});
    send_word(in_word_t'{ACT_FIND_DIR, '1,                     10'd0});
    send_word(in_word_t'{ACT_ADD_FILE, 64'h0,                  10'd0});
    send_word(in_word_t'{ACT_ADD_DIR,  '1,                     10'd1023});
    send_word(in_word_t'{ACT_ADD_FILE, 64'h41,                 10'd5});
    send_word(in_word_t'{ACT_ADD_DIR,  64'h0000_0000_0042_0041, 10'd7});
    send_word(in_word_t'{ACT_ADD_FILE, 64'h4100_0000_0000_0000, 10'd512});
    send_word(in_word_t'{ACT_ADD_FILE, '1,                     10'd3});
    send_word(in_word_t'{ACT_ADD_DIR,  64'h41,                 10'd9});
    send_word(in_word_t'{ACT_FIND,     '1,                     10'd0});
    send_word(in_word_t'{ACT_FIND_DIR, '1,                     10'd0});
    send_word(in_word_t'{ACT_FIND_DIR, 64'h41,                 10'd0});
    send_word(in_word_t'{ACT_FIND,     64'h0000_0000_0042_0041, 10'd0});
    send_word(in_word_t'{ACT_FIND,     64'h4100,               10'd0});
    send_word(in_word_t'{ACT_REMOVE,   64'h0,                  10'd0});
    send_word(in_word_t'{ACT_ADD_DIR,  64'h42,                 10'd1});
    send_word(in_word_t'{ACT_REMOVE,   64'h41,                 10'd0});
    send_word(in_word_t'{ACT_FIND,     64'h41,                 10'd0});
    send_word(in_word_t'{ACT_REMOVE + 3'd1, '1,                10'd1023});
    send_word(in_word_t'{ACT_REMOVE + 3'd2, 64'h42,            10'd0});
    send_word(in_word_t'{ACT_LAST_CODE, 64'h0000_0000_0042_0041, 10'd0});
    send_word(in_word_t'{ACT_FIND,     '1,                     10'd0});
    send_word(in_word_t'{ACT_REMOVE,   '1,                     10'd0});
    send_word(in_word_t'{ACT_FIND_DIR, 64'h0000_0000_0042_0041, 10'd0});
    directed_words = words_sent;
    wait_for_drain();

    for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = fresh_name();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct    = (phase == 0) ? 23 : (phase == 1) ? 62 : 0;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        mix = mix_t'($urandom_range(2));
        case ($urandom_range(2))
          0:       pool_n = 4;
          1:       pool_n = 16;
          default: pool_n = POOL_SIZE;
        endcase
        pool_lo = $urandom_range(POOL_SIZE - pool_n);
        burst   = $urandom_range(120, 20);
        repeat (burst) begin
          send_word(random_word(mix, pool_lo, pool_n));
          if ($urandom_range(99) == 0) wait_for_drain();
        end
        repeat (3) name_pool[$urandom_range(POOL_SIZE - 1)] = fresh_name();
      end
      wait_for_drain();
    end

    repeat (ENTRIES + 8) @(posedge clk);
    $display("Covered %0d command words (%0d directed) over three gap settings.",
             words_sent, directed_words);
    $display("Checked %0d result words, %0d of them reporting a full table.",
             results_seen, full_seen);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
